// File: design/bsws_pkg.sv
// Shared types, codes and defaults for the bounded stack with search.
package bsws_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;
    localparam int POS_W         = 4;
    localparam int CAP_RESET     = 16;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL_REJ  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY_REJ = 2'd2;

    localparam logic [WORD_W-1:0] EMPTY_TOP = '1;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WORD_W-1:0] key;
    } cell_ctl_t;

endpackage

// File: design/bsws_cell.sv
// One stack cell: holds a word, shifts on push or pop, compares against the key.
module bsws_cell (
    input  logic                        aclk,
    input  bsws_pkg::cell_ctl_t         ctl,
    input  logic [bsws_pkg::WORD_W-1:0] from_above,
    input  logic [bsws_pkg::WORD_W-1:0] from_below,
    output logic [bsws_pkg::WORD_W-1:0] data_out,
    output logic                        hit
);

    logic [bsws_pkg::WORD_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            data_reg <= from_above;
        end else if (ctl.pop) begin
            data_reg <= from_below;
        end
    end

    assign data_out = data_reg;
    assign hit      = (data_reg == ctl.key);

endmodule

// File: design/bsws_prio.sv
// Priority encoder: index of the lowest set hit, i.e. the match nearest the top.
module bsws_prio #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT,
    localparam int IW   = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0] hits,
    output logic             any,
    output logic [IW-1:0]    idx
);

    always_comb begin
        idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hits[i]) begin
                idx = IW'(i);
            end
        end
        any = |hits;
    end

endmodule

// File: design/bounded_stack_with_search.sv
// Top level of the bounded stack with search: cell row, control and result register.
//
//  channel  | direction | tdata                         | tuser
//  s_       | in        | operand_value                 | cmd
//  m_       | out       | top/count/full/empty/found/pos| status
//  cfg_     | in        | capacity (write only)         | -
//
// An item passes through the cell row, which shifts and compares, and then the encode stage,
// where the registered hit vector is encoded into the result register once the output is free.
// A new transfer is taken only while no item waits in the encode stage.
// Reset empties the stack and sets capacity to 16; cell contents are not cleared.
// A stall on m_ holds the result and blocks further input.
module bounded_stack_with_search #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] top_value, [36:32] entry_count, [37] is_full,
                                   // [38] is_empty, [39] found, [43:40] match_position
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int W  = bsws_pkg::WORD_W;
    localparam int CW = bsws_pkg::COUNT_W;

    logic [CW-1:0]                   cap_reg;
    logic [CW-1:0]                   cap_eff;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            pend_valid_reg;
    logic [bsws_pkg::STATUS_W-1:0]   pend_status_reg, status_next;
    logic                            pend_search_reg;
    logic [DEPTH-1:0]                hit_reg;
    logic                            out_valid_reg;
    logic [bsws_pkg::STATUS_W-1:0]   out_status_reg;
    logic [W-1:0]                    out_top_reg;
    logic [CW-1:0]                   out_count_reg;
    logic                            out_full_reg;
    logic                            out_empty_reg;
    logic                            out_found_reg;
    logic [bsws_pkg::POS_W-1:0]      out_pos_reg;

    logic                            in_xfer;
    logic                            out_free;
    logic                            is_full_now;
    bsws_pkg::cell_ctl_t             ctl;
    logic [W-1:0]                    cell_data [DEPTH];
    logic [DEPTH-1:0]                cell_hit;
    logic [DEPTH-1:0]                hit_masked;
    logic                            prio_any;
    logic [IW-1:0]                   prio_idx;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !pend_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (32'(cap_reg) > 32'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign is_full_now = (count_reg >= cap_eff);

    always_comb begin
        ctl.push    = 1'b0;
        ctl.pop     = 1'b0;
        ctl.key     = s_tdata;
        status_next = bsws_pkg::STATUS_OK;
        count_next  = count_reg;
        if (in_xfer) begin
            case (s_tuser)
                bsws_pkg::CMD_PUSH: begin
                    if (is_full_now) begin
                        status_next = bsws_pkg::STATUS_FULL_REJ;
                    end else begin
                        ctl.push   = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                bsws_pkg::CMD_POP: begin
                    if (count_reg == '0) begin
                        status_next = bsws_pkg::STATUS_EMPTY_REJ;
                    end else begin
                        ctl.pop    = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [W-1:0] above;
        logic [W-1:0] below;
        if (i == 0) begin : g_top
            assign above = s_tdata;
        end else begin : g_mid
            assign above = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_bot
            assign below = '0;
        end else begin : g_up
            assign below = cell_data[i+1];
        end
        bsws_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .from_above (above),
            .from_below (below),
            .data_out   (cell_data[i]),
            .hit        (cell_hit[i])
        );
        assign hit_masked[i] = cell_hit[i] && (32'(i) < 32'(count_reg));
    end

    bsws_prio #(.DEPTH(DEPTH)) u_prio (
        .hits (hit_reg),
        .any  (prio_any),
        .idx  (prio_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg        <= CW'(bsws_pkg::CAP_RESET);
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (in_xfer) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_valid_reg && out_free) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_valid_reg && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            pend_status_reg <= status_next;
            pend_search_reg <= (s_tuser == bsws_pkg::CMD_SEARCH);
            hit_reg         <= hit_masked;
        end
        if (pend_valid_reg && out_free) begin
            out_status_reg <= pend_status_reg;
            out_top_reg    <= (count_reg == '0) ? bsws_pkg::EMPTY_TOP : cell_data[0];
            out_count_reg  <= count_reg;
            out_full_reg   <= is_full_now;
            out_empty_reg  <= (count_reg == '0);
            out_found_reg  <= pend_search_reg && prio_any;
            out_pos_reg    <= (pend_search_reg && prio_any)
                              ? bsws_pkg::POS_W'(count_reg - CW'(1) - CW'(prio_idx))
                              : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_pos_reg, out_found_reg, out_empty_reg, out_full_reg,
                       out_count_reg, out_top_reg};

endmodule

// File: design/bsws_checker.sv
// Port-level checks for the bounded stack with search, bound to the top level.
module bsws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[38] == (m_tdata[36:32] == 5'd0)))
        else $error("is_empty disagrees with entry_count");

    a_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[38] |-> m_tdata[31:0] == bsws_pkg::EMPTY_TOP)
        else $error("empty stack without all-ones top");

    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bsws_pkg::STATUS_FULL_REJ |-> m_tdata[37] && !m_tdata[39])
        else $error("push rejected while not full");

    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[39] |-> m_tdata[43:40] == 4'd0)
        else $error("match_position set without a match");

endmodule

bind bounded_stack_with_search bsws_checker u_bsws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/testbench.sv
// Self-checking testbench for the bounded stack with search: directed and random streaming traffic, scored.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                           STACK_DEPTH = bsws_pkg::DEPTH_DEFAULT;
    localparam logic [bsws_pkg::CMD_W-1:0]   CMD_UNUSED  = 2'd3;
    localparam int                           CYCLE_LIMIT = 200000;
    localparam int                           PHASE_ITEMS = 120;

    typedef struct {
        logic [bsws_pkg::CMD_W-1:0]  op;
        logic [bsws_pkg::WORD_W-1:0] operand;
    } stack_cmd_t;

    typedef struct {
        logic [bsws_pkg::STATUS_W-1:0] status;
        logic [bsws_pkg::WORD_W-1:0]   top;
        logic [bsws_pkg::COUNT_W-1:0]  count;
        logic                          full;
        logic                          empty;
        logic                          found;
        logic [bsws_pkg::POS_W-1:0]    pos;
    } stack_view_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;   // [31:0] operand_value
    logic [1:0]  s_tuser     = '0;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;            // [31:0] top_value, [36:32] entry_count, [37] is_full,
                                     // [38] is_empty, [39] found, [43:40] match_position
    logic [1:0]  m_tuser;            // [1:0] status
    logic        cfg_wr_en   = 1'b0;
    logic [4:0]  cfg_wr_data = '0;

    bounded_stack_with_search #(.DEPTH(STACK_DEPTH)) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    stack_cmd_t  pending_cmds[$];
    stack_view_t expected_views[$];

    logic [bsws_pkg::WORD_W-1:0]  shadow_words[STACK_DEPTH];
    int                           shadow_fill  = 0;
    logic [bsws_pkg::COUNT_W-1:0] shadow_cap   = (bsws_pkg::COUNT_W)'(bsws_pkg::CAP_RESET);

    logic [1:0] idle_mode  = 2'd0;
    int         err_count  = 0;
    int         cycle_count = 0;
    int         transfers_out = 0;
    int         full_rejects = 0;
    int         empty_rejects = 0;
    int         search_hits = 0;
    int         cap_writes = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** bounded_stack_with_search: FAILED **");
            $finish;
        end
    end

    function automatic stack_view_t stack_apply(logic [bsws_pkg::CMD_W-1:0] op,
                                                logic [bsws_pkg::WORD_W-1:0] val);
        stack_view_t r;
        int          lim;
        int          i;
        r = '{default: '0};
        lim = (shadow_cap < 1) ? 1 : ((shadow_cap > STACK_DEPTH) ? STACK_DEPTH : int'(shadow_cap));
        case (op)
            bsws_pkg::CMD_PUSH: begin
                if (shadow_fill >= lim) begin
                    r.status = bsws_pkg::STATUS_FULL_REJ;
                end else begin
                    shadow_words[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            bsws_pkg::CMD_POP: begin
                if (shadow_fill == 0) begin
                    r.status = bsws_pkg::STATUS_EMPTY_REJ;
                end else begin
                    shadow_fill--;
                end
            end
            bsws_pkg::CMD_SEARCH: begin
                for (i = shadow_fill - 1; i >= 0 && !r.found; i--) begin
                    if (shadow_words[i] == val) begin
                        r.found = 1'b1;
                        r.pos   = (bsws_pkg::POS_W)'(i);
                    end
                end
            end
            default: ;
        endcase
        r.top   = (shadow_fill == 0) ? bsws_pkg::EMPTY_TOP : shadow_words[shadow_fill - 1];
        r.count = (bsws_pkg::COUNT_W)'(shadow_fill);
        r.full  = (shadow_fill >= lim);
        r.empty = (shadow_fill == 0);
        return r;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            2'd0:    return $urandom_range(99) < 36;
            2'd1:    return $urandom_range(99) < 53;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            2'd0:    return $urandom_range(99) < 53;
            2'd1:    return $urandom_range(99) < 36;
            default: return 1'b0;
        endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin : drive
        stack_cmd_t next_cmd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_views.push_back(stack_apply(s_tuser, s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() > 0 && !sender_idles()) begin
                    next_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_cmd.operand;
                    s_tuser  <= next_cmd.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        stack_view_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_views.size() == 0) begin
                    $error("result transfer with nothing expected: tuser 0x%0h tdata 0x%0h",
                           m_tuser, m_tdata);
                    err_count++;
                end else begin
                    want = expected_views.pop_front();
                    check_field("status",         want.status, m_tuser);
                    check_field("top_value",      want.top,    m_tdata[31:0]);
                    check_field("entry_count",    want.count,  m_tdata[36:32]);
                    check_field("is_full",        want.full,   m_tdata[37]);
                    check_field("is_empty",       want.empty,  m_tdata[38]);
                    check_field("found",          want.found,  m_tdata[39]);
                    check_field("match_position", want.pos,    m_tdata[43:40]);
                    transfers_out++;
                    if (want.status == bsws_pkg::STATUS_FULL_REJ)  full_rejects++;
                    if (want.status == bsws_pkg::STATUS_EMPTY_REJ) empty_rejects++;
                    if (want.found) search_hits++;
                end
            end
            // hold off the receiver once, long enough for the input side to back up
            if (!hold_done && transfers_out >= 150 && pending_cmds.size() > 30) begin
                hold_left = 120;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !receiver_idles();
            end
        end
    end

    task automatic queue_cmd(logic [bsws_pkg::CMD_W-1:0] op, logic [bsws_pkg::WORD_W-1:0] val);
        pending_cmds.push_back('{op: op, operand: val});
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_views.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [4:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_cap   = value;
        cap_writes++;
    endtask

    task automatic queue_random(int n);
        logic [bsws_pkg::WORD_W-1:0] hot[6];
        int                          push_bias;
        int                          k;
        int                          r;
        logic [bsws_pkg::CMD_W-1:0]  op;
        logic [bsws_pkg::WORD_W-1:0] val;
        hot[0] = 32'h8000_0000;
        hot[1] = 32'h7FFF_FFFF;
        hot[2] = 32'h0000_0000;
        hot[3] = 32'hFFFF_FFFF;
        hot[4] = $urandom;
        hot[5] = $urandom;
        push_bias = 50;
        for (k = 0; k < n; k++) begin
            if (k % 16 == 0) push_bias = $urandom_range(85, 15);
            r = $urandom_range(99);
            if (r < 3) begin
                op = CMD_UNUSED;
            end else if (r < 28) begin
                op = bsws_pkg::CMD_SEARCH;
            end else begin
                op = ($urandom_range(99) < push_bias) ? bsws_pkg::CMD_PUSH : bsws_pkg::CMD_POP;
            end
            val = ($urandom_range(99) < 60) ? hot[$urandom_range(5)] : $urandom;
            queue_cmd(op, val);
        end
    endtask

    initial begin : stimulus
        logic [4:0] caps[12];
        int         p;
        caps = '{5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd16, 5'd17, 5'd3, 5'd12, 5'd2, 5'd16, 5'd7};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        queue_cmd(bsws_pkg::CMD_POP,    32'h1234_5678);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        queue_cmd(CMD_UNUSED,           32'hDEAD_BEEF);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h8000_0000);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h7FFF_FFFF);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'hFFFF_FFFF);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h7FFF_FFFF);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h55AA_55AA);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h8000_0000);
        queue_cmd(CMD_UNUSED,           32'h0000_0001);
        queue_cmd(bsws_pkg::CMD_POP,    32'hFFFF_FFFF);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);

        // lower capacity below the current fill
        write_capacity(5'd2);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h0BAD_F00D);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'hA5A5_A5A5);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h5A5A_5A5A);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);

        // zero capacity acts as one
        write_capacity(5'd0);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h0000_0001);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h0000_0002);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);

        for (p = 0; p < 12; p++) begin
            write_capacity(caps[p]);
            idle_mode <= (p < 4) ? 2'd0 : ((p < 8) ? 2'd1 : 2'd2);
            queue_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Run covered %0d result transfers over %0d capacity writes.",
                 transfers_out, cap_writes);
        $display("Full rejections %0d, empty rejections %0d, search hits %0d.",
                 full_rejects, empty_rejects, search_hits);
        if (err_count == 0) begin
            $display("** bounded_stack_with_search: PASSED **");
        end else begin
            $display("** bounded_stack_with_search: FAILED **");
        end
        $finish;
    end

endmodule
